[src/rhs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rhs_pkg
// Shared types, register map and half-step phase table of the decoder.
// ----------------------------------------------------------------------------
package rhs_pkg;

   // register map
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic CSR_IDX_SENSITIVITY = 1'b0;
   localparam logic [7:0] SENSITIVITY_RESET = 8'd100;

   // phase codes of the half-step sequence
   localparam logic [2:0] PH_START     = 3'd0;
   localparam logic [2:0] PH_CCW_BEGIN = 3'd1;
   localparam logic [2:0] PH_CW_BEGIN  = 3'd2;
   localparam logic [2:0] PH_START_11  = 3'd3;
   localparam logic [2:0] PH_CW_11     = 3'd4;
   localparam logic [2:0] PH_CCW_11    = 3'd5;

   typedef enum logic [1:0] {
      DIR_IDLE = 2'b00,
      DIR_CW   = 2'b01,
      DIR_CCW  = 2'b10
   } dir_type;

   typedef struct packed {
      dir_type    dir;
      logic [2:0] phase;
   } phase_entry_type;

   // next phase and emitted direction for the current phase and pin pair {a,b}
   function automatic phase_entry_type phase_next(input logic [2:0] ph,
                                                  input logic [1:0] col);
      phase_entry_type e;
      e.dir = DIR_IDLE;
      case (ph)
         PH_CCW_BEGIN: begin
            case (col)
               2'b00:   begin e.phase = PH_START_11; e.dir = DIR_CCW; end
               2'b10:   e.phase = PH_CCW_BEGIN;
               default: e.phase = PH_START;
            endcase
         end
         PH_CW_BEGIN: begin
            case (col)
               2'b00:   begin e.phase = PH_START_11; e.dir = DIR_CW; end
               2'b01:   e.phase = PH_CW_BEGIN;
               default: e.phase = PH_START;
            endcase
         end
         PH_START_11: begin
            case (col)
               2'b00:   e.phase = PH_START_11;
               2'b01:   e.phase = PH_CCW_11;
               2'b10:   e.phase = PH_CW_11;
               default: e.phase = PH_START;
            endcase
         end
         PH_CW_11: begin
            case (col)
               2'b10:   e.phase = PH_CW_11;
               2'b11:   begin e.phase = PH_START; e.dir = DIR_CW; end
               default: e.phase = PH_START_11;
            endcase
         end
         PH_CCW_11: begin
            case (col)
               2'b01:   e.phase = PH_CCW_11;
               2'b11:   begin e.phase = PH_START; e.dir = DIR_CCW; end
               default: e.phase = PH_START_11;
            endcase
         end
         default: begin
            // start state, also taken by the unused codes
            case (col)
               2'b00:   e.phase = PH_START_11;
               2'b01:   e.phase = PH_CW_BEGIN;
               2'b10:   e.phase = PH_CCW_BEGIN;
               default: e.phase = PH_START;
            endcase
         end
      endcase
      return e;
   endfunction

endpackage
`default_nettype wire

[src/rhs_csr.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rhs_csr
// APB-style register slave holding the speed sensitivity threshold.
// ----------------------------------------------------------------------------
module rhs_csr (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          psel,
   input  wire logic                          penable,
   input  wire logic                          pwrite,
   input  wire logic [rhs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [rhs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [rhs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                               pready,
   output logic      [7:0]                    sensitivity
);
   import rhs_pkg::*;

   logic [7:0] sensitivity_ff;
   logic [7:0] sensitivity_in;
   logic       idx;

   // register index is the word address
   assign idx = paddr[CSR_ADDR_W-1];

   // take a write in the access phase
   always_comb begin
      sensitivity_in = sensitivity_ff;
      if (psel && penable && pwrite && (idx == CSR_IDX_SENSITIVITY)) begin
         sensitivity_in = pwdata[7:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sensitivity_ff <= SENSITIVITY_RESET;
      end else begin
         sensitivity_ff <= sensitivity_in;
      end
   end

   // read back
   always_comb begin
      prdata = '0;
      if (idx == CSR_IDX_SENSITIVITY) begin
         prdata = {{(CSR_DATA_W-8){1'b0}}, sensitivity_ff};
      end
   end

   assign pready      = 1'b1;
   assign sensitivity = sensitivity_ff;

endmodule
`default_nettype wire

[src/rotary_half_step_speed_decoder.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rotary_half_step_speed_decoder
// Half-step quadrature decoder with a three-speed step output.
//
// The req channel carries one word per pin sample: pin_a, pin_b and the
// millisecond timestamp now_ms. For every sample the rsp channel returns one
// word, step: -3..3, sign is direction (positive clockwise), magnitude the
// speed, zero when the sample completes no detent.
// A sample passes one input register, the phase table lookup with the
// interval subtract and compares, and one result register, which drives
// rsp_valid. A sample is accepted every cycle while rsp is taken; the
// phase and last-step-time registers update in the single compute stage.
// When rsp_ready is low the result register holds and one more sample can
// wait in the input register, after which req_ready drops.
// Reset sets the start phase, last step time zero and sensitivity 100, and
// empties both registers. sensitivity is written through the APB port at
// byte address 0; the user must write it only while the block is idle, and
// the block itself does not enforce this.
// ----------------------------------------------------------------------------
module rotary_half_step_speed_decoder (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic                           req_pin_a,
   input  wire logic                           req_pin_b,
   input  wire logic [31:0]                    req_now_ms,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic signed [2:0]                   rsp_step,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [rhs_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [rhs_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [rhs_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);
   import rhs_pkg::*;

   logic [7:0] sensitivity;

   logic        in_valid_ff;
   logic        pin_a_ff;
   logic        pin_b_ff;
   logic [31:0] now_ff;

   logic        out_valid_ff;
   logic [2:0]  step_ff;
   logic [2:0]  step_in;

   logic [2:0]  phase_ff;
   logic [2:0]  phase_in;
   logic [31:0] last_ff;
   logic [31:0] last_in;

   logic            out_adv;
   logic            fire;
   phase_entry_type entry;
   logic [31:0]     interval;
   logic [1:0]      mag;

   rhs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .sensitivity (sensitivity)
   );

   // pipeline flow control
   assign out_adv   = !out_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_adv;
   assign req_ready = !in_valid_ff || out_adv;

   // phase step, interval and speed grade
   always_comb begin
      entry    = phase_next(phase_ff, {pin_a_ff, pin_b_ff});
      interval = now_ff - last_ff;
      if (interval < {25'd0, sensitivity[7:1]}) begin
         mag = 2'd3;
      end else if (interval < {24'd0, sensitivity}) begin
         mag = 2'd2;
      end else begin
         mag = 2'd1;
      end
      phase_in = phase_ff;
      last_in  = last_ff;
      step_in  = step_ff;
      if (fire) begin
         phase_in = entry.phase;
         case (entry.dir)
            DIR_CW: begin
               step_in = {1'b0, mag};
               last_in = now_ff;
            end
            DIR_CCW: begin
               step_in = 3'd0 - {1'b0, mag};
               last_in = now_ff;
            end
            default: step_in = 3'd0;
         endcase
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_START;
         last_ff      <= '0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (out_adv) begin
            out_valid_ff <= in_valid_ff;
         end
         phase_ff <= phase_in;
         last_ff  <= last_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         pin_a_ff <= req_pin_a;
         pin_b_ff <= req_pin_b;
         now_ff   <= req_now_ms;
      end
      step_ff <= step_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_step  = step_ff;

`ifndef SYNTHESIS
   // a held sample behind a stalled result blocks new words
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && out_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("req_ready high with both stages full and rsp stalled");

   // last step time moves only with a nonzero step result
   a_last_on_step: assert property (@(posedge clock) disable iff (reset)
      ($past(!reset) && (last_ff != $past(last_ff))) |-> (rsp_valid && rsp_step != 3'sd0))
      else $error("last step time changed without a step");

   // magnitude never exceeds three
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_step != 3'b100))
      else $error("step out of range");

   // the compute stage never updates state without a waiting sample
   a_phase_hold: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |=> $stable(phase_ff))
      else $error("phase changed with no sample");
`endif

endmodule
`default_nettype wire
